// ===== hdl/utf8wd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8wd_pkg
// Shared types and constants for the utf-8 window decoder.
// ----------------------------------------------------------------------------
package utf8wd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AVAIL_W = 3;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned USED_W  = 3;

  // lead byte ranges
  localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;

  // continuation bytes are 10xxxxxx
  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam logic [CP_W-1:0] RPL_CODE = 21'h00FFFD;

  // bytes-used codes
  localparam logic [USED_W-1:0] USED_NONE = 3'd0;
  localparam logic [USED_W-1:0] USED_ONE  = 3'd1;
  localparam logic [USED_W-1:0] USED_TWO  = 3'd2;
  localparam logic [USED_W-1:0] USED_THREE = 3'd3;
  localparam logic [USED_W-1:0] USED_FOUR = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_first;
    logic [BYTE_W-1:0]  byte_second;
    logic [BYTE_W-1:0]  byte_third;
    logic [BYTE_W-1:0]  byte_fourth;
    logic [AVAIL_W-1:0] avail;
  } win_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [USED_W-1:0] consumed;
  } dec_res_t;

endpackage : utf8wd_pkg
`default_nettype wire

// ===== hdl/utf8wd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8wd_decode
// Combinational decode of one utf-8 sequence from a four-byte window.
// ----------------------------------------------------------------------------
module utf8wd_decode (
  input  utf8wd_pkg::win_t     win,
  output utf8wd_pkg::dec_res_t res
);

  logic [utf8wd_pkg::BYTE_W-1:0] b0;
  logic [utf8wd_pkg::BYTE_W-1:0] b1;
  logic [utf8wd_pkg::BYTE_W-1:0] b2;
  logic [utf8wd_pkg::BYTE_W-1:0] b3;
  logic has1, has2, has3, has4;
  logic c1, c2, c3;
  logic lead2, lead3, lead4;

  assign b0 = win.byte_first;
  assign b1 = win.byte_second;
  assign b2 = win.byte_third;
  assign b3 = win.byte_fourth;

  // avail above four saturates
  assign has1 = (win.avail != '0);
  assign has2 = win.avail[2] | win.avail[1];
  assign has3 = win.avail[2] | (win.avail[1] & win.avail[0]);
  assign has4 = win.avail[2];

  assign c1 = (b1[7:6] == utf8wd_pkg::CONT_TAG);
  assign c2 = (b2[7:6] == utf8wd_pkg::CONT_TAG);
  assign c3 = (b3[7:6] == utf8wd_pkg::CONT_TAG);

  assign lead2 = (b0 >= utf8wd_pkg::LEAD2_LO) && (b0 <= utf8wd_pkg::LEAD2_HI);
  assign lead3 = (b0 >= utf8wd_pkg::LEAD3_LO) && (b0 <= utf8wd_pkg::LEAD3_HI);
  assign lead4 = (b0 >= utf8wd_pkg::LEAD4_LO) && (b0 <= utf8wd_pkg::LEAD4_HI);

  always_comb begin
    res.code_point = '0;
    res.consumed   = utf8wd_pkg::USED_NONE;
    if (!has1) begin
      res.code_point = '0;
      res.consumed   = utf8wd_pkg::USED_NONE;
    end else if (!b0[7]) begin
      res.code_point = {13'd0, b0};
      res.consumed   = utf8wd_pkg::USED_ONE;
    end else if (lead2) begin
      if (!has2) begin
        res.consumed = utf8wd_pkg::USED_NONE;
      end else if (!c1) begin
        res.code_point = utf8wd_pkg::RPL_CODE;
        res.consumed   = utf8wd_pkg::USED_ONE;
      end else begin
        res.code_point = {10'd0, b0[4:0], b1[5:0]};
        res.consumed   = utf8wd_pkg::USED_TWO;
      end
    end else if (lead3) begin
      if (!has3) begin
        res.consumed = utf8wd_pkg::USED_NONE;
      end else if (!(c1 && c2)) begin
        res.code_point = utf8wd_pkg::RPL_CODE;
        res.consumed   = utf8wd_pkg::USED_ONE;
      end else begin
        res.code_point = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        res.consumed   = utf8wd_pkg::USED_THREE;
      end
    end else if (lead4) begin
      if (!has4) begin
        res.consumed = utf8wd_pkg::USED_NONE;
      end else if (!(c1 && c2 && c3)) begin
        res.code_point = utf8wd_pkg::RPL_CODE;
        res.consumed   = utf8wd_pkg::USED_ONE;
      end else begin
        res.code_point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        res.consumed   = utf8wd_pkg::USED_FOUR;
      end
    end else begin
      res.code_point = utf8wd_pkg::RPL_CODE;
      res.consumed   = utf8wd_pkg::USED_ONE;
    end
  end

endmodule : utf8wd_decode
`default_nettype wire

// ===== hdl/utf8_window_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_window_decoder_unit
// Decodes one utf-8 sequence per transaction from a window of up to four bytes.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The unit takes a new window every
// clock cycle and gives one result per cycle as long as the result side keeps
// out_ready high. A window is captured in an input register, decoded by short
// combinational logic and captured in the result register, which drives
// out_*. Each of the two registers takes new data when it is empty or when
// the stage after it hands its data on, so a stalled result blocks input
// only once both registers are full. consumed 0 means an empty window or a
// lead that needs more bytes than avail gives; a bad continuation or an
// invalid lead gives U+FFFD with consumed 1. Three- and four-byte overlong
// forms, surrogates and values above 10FFFF pass as decoded. Nothing is kept
// between transactions.
module utf8_window_decoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // window channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [utf8wd_pkg::BYTE_W-1:0]     in_byte_first,
  input  wire logic [utf8wd_pkg::BYTE_W-1:0]     in_byte_second,
  input  wire logic [utf8wd_pkg::BYTE_W-1:0]     in_byte_third,
  input  wire logic [utf8wd_pkg::BYTE_W-1:0]     in_byte_fourth,
  input  wire logic [utf8wd_pkg::AVAIL_W-1:0]    in_avail,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [utf8wd_pkg::CP_W-1:0]            out_code_point,
  output logic [utf8wd_pkg::USED_W-1:0]          out_consumed
);

  // input register stage
  logic                 win_vld_r, win_vld_nxt;
  utf8wd_pkg::win_t     win_r;
  // result register stage
  logic                 res_vld_r, res_vld_nxt;
  utf8wd_pkg::dec_res_t res_r;
  utf8wd_pkg::dec_res_t dec_res;

  logic res_load;   // result register takes the decoded window
  logic win_load;   // input register takes a new window

  // result stage is free when empty or when its transaction leaves now
  assign res_load = !res_vld_r || out_ready;
  // input stage is free when empty or when its window moves on now
  assign in_ready = !win_vld_r || res_load;
  assign win_load = in_valid && in_ready;

  utf8wd_decode u_decode (
    .win (win_r),
    .res (dec_res)
  );

  always_comb begin
    win_vld_nxt = win_vld_r;
    if (in_ready) begin
      win_vld_nxt = in_valid;
    end
    res_vld_nxt = res_vld_r;
    if (res_load) begin
      res_vld_nxt = win_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      win_vld_r <= win_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (win_load) begin
      win_r.byte_first  <= in_byte_first;
      win_r.byte_second <= in_byte_second;
      win_r.byte_third  <= in_byte_third;
      win_r.byte_fourth <= in_byte_fourth;
      win_r.avail       <= in_avail;
    end
    if (res_load && win_vld_r) begin
      res_r <= dec_res;
    end
  end

  assign out_valid      = res_vld_r;
  assign out_code_point = res_r.code_point;
  assign out_consumed   = res_r.consumed;

  // a stalled result leaves a full input stage full
  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld_r && res_vld_r && !out_ready |=> win_vld_r)
    else $error("input stage lost a window while the result stalled");

  // a window held behind a stalled result keeps its bytes
  a_win_stable: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld_r && res_vld_r && !out_ready |=> $stable(win_r))
    else $error("input stage changed while the result stalled");

  // no bytes consumed means no code point
  a_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_consumed == utf8wd_pkg::USED_NONE) |-> (out_code_point == '0))
    else $error("code point not zero with nothing consumed");

  // one byte consumed is ascii or the replacement
  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_consumed == utf8wd_pkg::USED_ONE)
      |-> (out_code_point < 21'h80) || (out_code_point == utf8wd_pkg::RPL_CODE))
    else $error("single-byte result out of range");

  // two-byte results fit in eleven bits and consumed never exceeds four
  a_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_consumed <= utf8wd_pkg::USED_FOUR) &&
      ((out_consumed != utf8wd_pkg::USED_TWO) || (out_code_point < 21'h800)))
    else $error("consumed count or two-byte value out of range");

endmodule : utf8_window_decoder_unit
`default_nettype wire

// ===== tb/tb_utf8_window_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_window_decoder_unit
// Self-checking bench for the utf-8 window decoder. A queue of byte windows
// (directed corner cases, then mostly well-formed random sequences mixed with
// broken ones and raw noise) feeds a valid/ready driver. Each window is decoded
// by a local predictor when it goes on the bus, and every result transaction
// is compared field by field against the oldest prediction. Both sides idle
// at random, with one long calm stretch in the middle of the run.
// ----------------------------------------------------------------------------
module tb_utf8_window_decoder_unit;

  logic clk;
  logic rst_n = 1'b0;

  // window channel
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [utf8wd_pkg::BYTE_W-1:0]  in_byte_first  = '0;
  logic [utf8wd_pkg::BYTE_W-1:0]  in_byte_second = '0;
  logic [utf8wd_pkg::BYTE_W-1:0]  in_byte_third  = '0;
  logic [utf8wd_pkg::BYTE_W-1:0]  in_byte_fourth = '0;
  logic [utf8wd_pkg::AVAIL_W-1:0] in_avail       = '0;

  // result channel
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [utf8wd_pkg::CP_W-1:0]    out_code_point;
  logic [utf8wd_pkg::USED_W-1:0]  out_consumed;

  // windows waiting to be driven, and decodes waiting to come out
  utf8wd_pkg::win_t     pending_windows[$];
  utf8wd_pkg::dec_res_t expected_decodes[$];

  int windows_sent  = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int consumed_hist[0:7];

  // no idling on either side while the count is inside this window
  localparam int CALM_FROM = 200;
  localparam int CALM_TO   = 350;
  localparam int IDLE_PCT  = 10;

  utf8_window_decoder_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_first  (in_byte_first),
    .in_byte_second (in_byte_second),
    .in_byte_third  (in_byte_third),
    .in_byte_fourth (in_byte_fourth),
    .in_avail       (in_avail),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_consumed   (out_consumed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic bit is_continuation(logic [utf8wd_pkg::BYTE_W-1:0] b);
    return b[7:6] == utf8wd_pkg::CONT_TAG;
  endfunction

  function automatic utf8wd_pkg::dec_res_t decode_window(utf8wd_pkg::win_t w);
    logic [utf8wd_pkg::AVAIL_W-1:0] n;
    utf8wd_pkg::dec_res_t           r;
    // avail above four saturates
    n = (w.avail > 3'd4) ? 3'd4 : w.avail;
    r.code_point = '0;
    r.consumed   = utf8wd_pkg::USED_NONE;
    if (n == 3'd0) begin
      // empty window: nothing decoded
    end else if (w.byte_first[7] == 1'b0) begin
      r.code_point = {13'b0, w.byte_first};
      r.consumed   = utf8wd_pkg::USED_ONE;
    end else if (w.byte_first >= utf8wd_pkg::LEAD2_LO &&
                 w.byte_first <= utf8wd_pkg::LEAD2_HI) begin
      if (n < 3'd2) begin
        // short window, continuation bytes not looked at
      end else if (!is_continuation(w.byte_second)) begin
        r.code_point = utf8wd_pkg::RPL_CODE;
        r.consumed   = utf8wd_pkg::USED_ONE;
      end else begin
        r.code_point = {10'b0, w.byte_first[4:0], w.byte_second[5:0]};
        r.consumed   = utf8wd_pkg::USED_TWO;
      end
    end else if (w.byte_first >= utf8wd_pkg::LEAD3_LO &&
                 w.byte_first <= utf8wd_pkg::LEAD3_HI) begin
      if (n < 3'd3) begin
      end else if (!is_continuation(w.byte_second) || !is_continuation(w.byte_third)) begin
        r.code_point = utf8wd_pkg::RPL_CODE;
        r.consumed   = utf8wd_pkg::USED_ONE;
      end else begin
        r.code_point = {5'b0, w.byte_first[3:0], w.byte_second[5:0], w.byte_third[5:0]};
        r.consumed   = utf8wd_pkg::USED_THREE;
      end
    end else if (w.byte_first >= utf8wd_pkg::LEAD4_LO &&
                 w.byte_first <= utf8wd_pkg::LEAD4_HI) begin
      if (n < 3'd4) begin
      end else if (!is_continuation(w.byte_second) || !is_continuation(w.byte_third) ||
                   !is_continuation(w.byte_fourth)) begin
        r.code_point = utf8wd_pkg::RPL_CODE;
        r.consumed   = utf8wd_pkg::USED_ONE;
      end else begin
        r.code_point = {w.byte_first[2:0], w.byte_second[5:0], w.byte_third[5:0],
                        w.byte_fourth[5:0]};
        r.consumed   = utf8wd_pkg::USED_FOUR;
      end
    end else begin
      // stray continuation, c0/c1 or f5-ff lead
      r.code_point = utf8wd_pkg::RPL_CODE;
      r.consumed   = utf8wd_pkg::USED_ONE;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus generation
  // --------------------------------------------------------------------------
  task automatic add_window(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [2:0] avail);
    utf8wd_pkg::win_t w;
    w.byte_first  = b0;
    w.byte_second = b1;
    w.byte_third  = b2;
    w.byte_fourth = b3;
    w.avail       = avail;
    pending_windows.push_back(w);
  endtask

  // mostly well-formed sequences with random payload, some short or broken,
  // the rest raw noise
  function automatic utf8wd_pkg::win_t random_window();
    utf8wd_pkg::win_t w;
    int unsigned      len;
    int unsigned      bad_pos;
    logic [1:0]       bad_tag;
    w.byte_first  = 8'($urandom);
    w.byte_second = 8'($urandom);
    w.byte_third  = 8'($urandom);
    w.byte_fourth = 8'($urandom);
    w.avail       = 3'($urandom);
    if ($urandom_range(99) < 70) begin
      len = $urandom_range(4, 1);
      case (len)
        1: w.byte_first = 8'($urandom_range(8'h7F, 0));
        2: w.byte_first = 8'($urandom_range(utf8wd_pkg::LEAD2_HI, utf8wd_pkg::LEAD2_LO));
        3: w.byte_first = 8'($urandom_range(utf8wd_pkg::LEAD3_HI, utf8wd_pkg::LEAD3_LO));
        default: w.byte_first = 8'($urandom_range(utf8wd_pkg::LEAD4_HI,
                                                  utf8wd_pkg::LEAD4_LO));
      endcase
      w.byte_second = {utf8wd_pkg::CONT_TAG, w.byte_second[5:0]};
      w.byte_third  = {utf8wd_pkg::CONT_TAG, w.byte_third[5:0]};
      w.byte_fourth = {utf8wd_pkg::CONT_TAG, w.byte_fourth[5:0]};
      // usually enough bytes, sometimes a short window
      if ($urandom_range(99) < 15)
        w.avail = 3'($urandom_range(len - 1, 0));
      else
        w.avail = 3'($urandom_range(7, len));
      // break one of the required continuation bytes
      if (len > 1 && $urandom_range(99) < 15) begin
        bad_pos = $urandom_range(len, 2);
        bad_tag = 2'($urandom_range(2));
        if (bad_tag == utf8wd_pkg::CONT_TAG)
          bad_tag = 2'b11;
        case (bad_pos)
          2: w.byte_second[7:6] = bad_tag;
          3: w.byte_third[7:6]  = bad_tag;
          default: w.byte_fourth[7:6] = bad_tag;
        endcase
      end
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // driver: puts the next window on the bus once the current one is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : window_driver
    utf8wd_pkg::win_t nxt;
    bit               slot_free;
    bit               calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid || in_ready;
      calm      = windows_sent >= CALM_FROM && windows_sent < CALM_TO;
      if (slot_free) begin
        if (pending_windows.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_windows.pop_front();
          in_byte_first  <= nxt.byte_first;
          in_byte_second <= nxt.byte_second;
          in_byte_third  <= nxt.byte_third;
          in_byte_fourth <= nxt.byte_fourth;
          in_avail       <= nxt.avail;
          in_valid       <= 1'b1;
          // valid holds until taken, so this window will be accepted in order
          expected_decodes.push_back(decode_window(nxt));
          windows_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure and result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    utf8wd_pkg::dec_res_t exp_res;
    bit                   calm;
    calm = results_seen >= CALM_FROM && results_seen < CALM_TO;
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      consumed_hist[out_consumed]++;
      if (expected_decodes.size() == 0) begin
        $error("unexpected result transaction: code_point %h consumed %0d",
               out_code_point, out_consumed);
        mismatches++;
      end else begin
        exp_res = expected_decodes.pop_front();
        if (out_code_point !== exp_res.code_point) begin
          $error("code_point mismatch: expected %h, got %h",
                 exp_res.code_point, out_code_point);
          mismatches++;
        end
        if (out_consumed !== exp_res.consumed) begin
          $error("consumed mismatch: expected %0d, got %0d",
                 exp_res.consumed, out_consumed);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    for (int i = 0; i < 8; i++)
      consumed_hist[i] = 0;

    // empty window, ascii extremes
    add_window(8'h41, 8'h80, 8'h80, 8'h80, 3'd0);
    add_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1);
    add_window(8'h7F, 8'h00, 8'h00, 8'h00, 3'd4);
    // two-byte lead: both ends, short window, bad continuation
    add_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
    add_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd4);
    add_window(8'hC2, 8'h41, 8'h00, 8'h00, 3'd1);
    add_window(8'hC2, 8'h41, 8'h00, 8'h00, 3'd2);
    // three-byte lead: both ends, overlong and surrogate pass as decoded, short, bad continuation
    add_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
    add_window(8'hEF, 8'hBF, 8'hBF, 8'h00, 3'd3);
    add_window(8'hE0, 8'h80, 8'h80, 8'h00, 3'd3);
    add_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
    add_window(8'hE1, 8'h80, 8'h41, 8'h00, 3'd2);
    add_window(8'hE2, 8'h80, 8'hC0, 8'h00, 3'd3);
    // four-byte lead: smallest, 10ffff, above 10ffff, short, bad last byte
    add_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
    add_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    add_window(8'hF4, 8'hBF, 8'hBF, 8'hBF, 3'd4);
    add_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd3);
    add_window(8'hF1, 8'h80, 8'h80, 8'h7F, 3'd4);
    // leads that are never valid
    add_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
    add_window(8'hC0, 8'hAF, 8'h00, 8'h00, 3'd2);
    add_window(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd2);
    add_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd4);
    add_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
    // avail above four saturates
    add_window(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd5);
    add_window(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd7);

    for (int i = 0; i < 550; i++)
      pending_windows.push_back(random_window());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // all windows accepted, then all results drained, then a short tail
    while (pending_windows.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_decodes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_decodes.size() != 0) begin
      $error("%0d expected results never arrived", expected_decodes.size());
      mismatches++;
    end

    $display("decoded %0d windows, %0d results checked", windows_sent, results_seen);
    $display("by bytes used: none %0d, one %0d, two %0d, three %0d, four %0d",
             consumed_hist[0], consumed_hist[1], consumed_hist[2],
             consumed_hist[3], consumed_hist[4]);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("timeout: %0d results still outstanding", expected_decodes.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
